@@ rtl/core/flow_meter_idle_active_timeout_top_macros.svh @@
// ----------------------------------------------------------------------------
// flow meter assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef FLOW_METER_IDLE_ACTIVE_TIMEOUT_TOP_MACROS_SVH
`define FLOW_METER_IDLE_ACTIVE_TIMEOUT_TOP_MACROS_SVH

// expression must hold at every edge outside reset
`define FMIT_ASSERT_COMB(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("flow meter check failed");

// consequent must hold in the cycle after the antecedent
`define FMIT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("flow meter sequence check failed");

`endif

@@ rtl/core/fmit_pkg.sv @@
// ----------------------------------------------------------------------------
// fmit_pkg
// types and constants shared by the flow meter modules
// ----------------------------------------------------------------------------
package fmit_pkg;

   localparam int TS_W    = 48;
   localparam int BYTE_W  = 48;
   localparam int PKT_W   = 32;
   localparam int LEN_W   = 16;
   localparam int TO_W    = 27;
   localparam int US_W    = 37;
   localparam int IDX_W   = 2;

   localparam logic [9:0]      US_PER_MS     = 10'd1000;
   localparam logic [9:0]      MS_ROUND      = 10'd999;
   localparam logic [TO_W-1:0] IDLE_MS_RST   = 27'd500;
   localparam logic [TO_W-1:0] ACTIVE_MS_RST = 27'd100;

   localparam logic [1:0] KIND_ACTIVE = 2'd0;
   localparam logic [1:0] KIND_IDLE   = 2'd1;
   localparam logic [1:0] KIND_DROP   = 2'd2;

   localparam logic MODE_PACKET = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   localparam logic [IDX_W-1:0] CSR_IDLE_TIMEOUT   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_ACTIVE_TIMEOUT = 2'd1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   typedef struct packed {
      logic [31:0] sip;
      logic [31:0] dip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  proto;
   } flow_key_type;

   typedef struct packed {
      logic              mode;
      logic [TS_W-1:0]   now_us;
      flow_key_type      key;
      logic [LEN_W-1:0]  len;
   } item_type;

   typedef struct packed {
      flow_key_type      key;
      logic [TS_W-1:0]   ts_start;
      logic [TS_W-1:0]   ts_stop;
      logic [BYTE_W-1:0] bytes;
      logic [PKT_W-1:0]  pkts;
   } rec_type;

   typedef struct packed {
      logic [1:0] kind;
      rec_type    rec;
      logic       last;
   } result_type;

endpackage

@@ rtl/core/fmit_req_if.sv @@
// ----------------------------------------------------------------------------
// fmit_req_if
// packet and tick item channel
// ----------------------------------------------------------------------------
interface fmit_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [47:0] now_us;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [15:0] l4_sport;
   logic [15:0] l4_dport;
   logic [7:0]  protocol;
   logic [15:0] packet_length;

   modport source (output valid, mode, now_us, src_ip, dst_ip, l4_sport, l4_dport,
                   protocol, packet_length, input ready);
   modport sink (input valid, mode, now_us, src_ip, dst_ip, l4_sport, l4_dport,
                 protocol, packet_length, output ready);
endinterface

@@ rtl/core/fmit_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fmit_rsp_if
// flow record result channel
// ----------------------------------------------------------------------------
interface fmit_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] rec_src_ip;
   logic [31:0] rec_dst_ip;
   logic [15:0] rec_l4_sport;
   logic [15:0] rec_l4_dport;
   logic [7:0]  rec_protocol;
   logic [47:0] start_us;
   logic [47:0] end_us;
   logic [47:0] byte_count;
   logic [31:0] packet_count;
   logic        last;

   modport source (output valid, kind, rec_src_ip, rec_dst_ip, rec_l4_sport,
                   rec_l4_dport, rec_protocol, start_us, end_us, byte_count,
                   packet_count, last, input ready);
   modport sink (input valid, kind, rec_src_ip, rec_dst_ip, rec_l4_sport,
                 rec_l4_dport, rec_protocol, start_us, end_us, byte_count,
                 packet_count, last, output ready);
endinterface

@@ rtl/core/fmit_csr_if.sv @@
// ----------------------------------------------------------------------------
// fmit_csr_if
// configuration write channel
// ----------------------------------------------------------------------------
interface fmit_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [26:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/fmit_front.sv @@
// ----------------------------------------------------------------------------
// fmit_front
// accepts items, packs the key and queues them for the engine
// ----------------------------------------------------------------------------
module fmit_front
   import fmit_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   fmit_req_if.sink  req_ch,
   output logic      q_vld,
   input  logic      q_pop,
   output item_type  q_item
);

   item_type              q_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       cnt_ff, cnt_in;
   item_type              in_item;
   logic                  push;
   logic                  pop;

   always_comb begin
      in_item.mode       = req_ch.mode;
      in_item.now_us     = req_ch.now_us;
      in_item.key.sip    = req_ch.src_ip;
      in_item.key.dip    = req_ch.dst_ip;
      in_item.key.sport  = req_ch.l4_sport;
      in_item.key.dport  = req_ch.l4_dport;
      in_item.key.proto  = req_ch.protocol;
      in_item.len        = req_ch.packet_length;
   end

   assign req_ch.ready = (cnt_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign q_vld        = (cnt_ff != '0);
   assign pop          = q_pop && q_vld;
   assign q_item       = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ rtl/core/fmit_engine.sv @@
// ----------------------------------------------------------------------------
// fmit_engine
// flow table lookup, update, expiry ring sweep and result register
// ----------------------------------------------------------------------------
module fmit_engine
   import fmit_pkg::*;
#(
   parameter int FLOW_ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_vld,
   output logic             q_pop,
   input  item_type         q_item,
   input  logic [US_W-1:0]  idle_us,
   input  logic [US_W-1:0]  act_lim_us,
   fmit_rsp_if.source       rsp_ch
);

   localparam int IW = $clog2(FLOW_ENTRIES);
   localparam int CW = $clog2(FLOW_ENTRIES + 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SCAN = 4'd1;
   localparam logic [3:0] ST_AGE  = 4'd2;
   localparam logic [3:0] ST_PKT  = 4'd3;
   localparam logic [3:0] ST_MISS = 4'd4;
   localparam logic [3:0] ST_TLIM = 4'd5;
   localparam logic [3:0] ST_TRD  = 4'd6;
   localparam logic [3:0] ST_TEN  = 4'd7;
   localparam logic [3:0] ST_TDEC = 4'd8;
   localparam logic [3:0] ST_TEND = 4'd9;

   typedef struct packed {
      logic [IW-1:0]   idx;
      logic [TS_W-1:0] chk;
   } ring_slot_type;

   rec_type        ent_mem [FLOW_ENTRIES];
   ring_slot_type  ring_mem [FLOW_ENTRIES];

   logic [3:0]              state_ff, state_in;
   item_type                cur_ff, cur_in;
   logic [FLOW_ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;

   logic                    ent_we;
   logic [IW-1:0]           ent_waddr, ent_raddr;
   rec_type                 ent_wdata, ent_rdata_ff;
   logic                    ring_we;
   logic [IW-1:0]           ring_waddr, ring_raddr;
   ring_slot_type           ring_wdata, ring_rdata_ff;

   logic [CW-1:0]           iss_ff, iss_in;
   logic                    p_vld_ff, p_vld_in;
   logic [IW-1:0]           p_idx_ff, p_idx_in;
   logic [IW-1:0]           hit_idx_ff, hit_idx_in;
   rec_type                 hit_rec_ff, hit_rec_in;
   logic                    free_ok_ff, free_ok_in;
   logic [IW-1:0]           free_idx_ff, free_idx_in;
   logic                    age_gt_ff, age_gt_in;

   logic [TS_W-1:0]         limit_ff, limit_in;
   logic [CW-1:0]           visits_ff, visits_in;
   logic [CW-1:0]           v_ff, v_in;
   logic [IW-1:0]           e_ff, e_in;
   logic [TS_W-1:0]         chk_ff, chk_in;
   logic                    pend_vld_ff, pend_vld_in;
   result_type              pend_ff, pend_in;

   logic                    out_vld_ff, out_vld_in;
   result_type              out_ff, out_in;
   logic                    out_free;

   logic [CW:0]             pos_sum, pos_wrap;
   logic [IW-1:0]           push_pos;
   logic [TS_W-1:0]         age;
   rec_type                 base_rec, upd_rec;
   logic [BYTE_W:0]         byte_sum;

   assign out_free = !out_vld_ff || rsp_ch.ready;

   // next free ring slot behind the live entries
   always_comb begin
      pos_sum  = (CW+1)'(head_ff) + (CW+1)'(count_ff);
      pos_wrap = (pos_sum >= (CW+1)'(FLOW_ENTRIES)) ?
                 pos_sum - (CW+1)'(FLOW_ENTRIES) : pos_sum;
      push_pos = pos_wrap[IW-1:0];
   end

   // packet update on the hit entry, restarted when the active export fires
   always_comb begin
      base_rec = hit_rec_ff;
      if (age_gt_ff) begin
         base_rec.ts_start = cur_ff.now_us;
         base_rec.ts_stop  = cur_ff.now_us;
         base_rec.bytes    = '0;
         base_rec.pkts     = '0;
      end
      upd_rec = base_rec;
      if (cur_ff.now_us < base_rec.ts_start) begin
         upd_rec.ts_start = cur_ff.now_us;
      end
      if (cur_ff.now_us > base_rec.ts_stop) begin
         upd_rec.ts_stop = cur_ff.now_us;
      end
      byte_sum = {1'b0, base_rec.bytes} + (BYTE_W+1)'(cur_ff.len);
      upd_rec.bytes = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
      upd_rec.pkts  = (&base_rec.pkts) ? base_rec.pkts : base_rec.pkts + 1'b1;
   end

   assign age = cur_ff.now_us - hit_rec_ff.ts_start;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      valid_in    = valid_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      q_pop       = 1'b0;
      ent_we      = 1'b0;
      ent_waddr   = hit_idx_ff;
      ent_wdata   = upd_rec;
      ent_raddr   = iss_ff[IW-1:0];
      ring_we     = 1'b0;
      ring_waddr  = push_pos;
      ring_wdata  = '{idx: e_ff, chk: cur_ff.now_us};
      ring_raddr  = head_ff;
      iss_in      = iss_ff;
      p_vld_in    = 1'b0;
      p_idx_in    = p_idx_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rec_in  = hit_rec_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      age_gt_in   = age_gt_ff;
      limit_in    = limit_ff;
      visits_in   = visits_ff;
      v_in        = v_ff;
      e_in        = e_ff;
      chk_in      = chk_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff && !rsp_ch.ready;
      out_in      = out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_vld) begin
               q_pop      = 1'b1;
               cur_in     = q_item;
               iss_in     = '0;
               free_ok_in = 1'b0;
               state_in   = (q_item.mode == MODE_TICK) ? ST_TLIM : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one read issued per cycle, compared in the cycle after it is issued
            if (iss_ff < CW'(FLOW_ENTRIES)) begin
               iss_in   = iss_ff + 1'b1;
               p_vld_in = 1'b1;
               p_idx_in = iss_ff[IW-1:0];
            end
            if (p_vld_ff) begin
               if (valid_ff[p_idx_ff] && ent_rdata_ff.key == cur_ff.key) begin
                  hit_idx_in = p_idx_ff;
                  hit_rec_in = ent_rdata_ff;
                  p_vld_in   = 1'b0;
                  state_in   = ST_AGE;
               end else if (!valid_ff[p_idx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = p_idx_ff;
               end
            end
            if (state_in == ST_SCAN && !p_vld_ff && iss_ff == CW'(FLOW_ENTRIES)) begin
               state_in = ST_MISS;
            end
         end
         ST_AGE: begin
            age_gt_in = (cur_ff.now_us >= hit_rec_ff.ts_start) &&
                        (age > TS_W'(act_lim_us));
            state_in  = ST_PKT;
         end
         ST_PKT: begin
            if (!age_gt_ff || out_free) begin
               ent_we = 1'b1;
               if (age_gt_ff) begin
                  out_vld_in          = 1'b1;
                  out_in.kind         = KIND_ACTIVE;
                  out_in.rec          = hit_rec_ff;
                  out_in.rec.ts_stop  = (cur_ff.now_us > hit_rec_ff.ts_stop) ?
                                        cur_ff.now_us : hit_rec_ff.ts_stop;
                  out_in.last         = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_MISS: begin
            if (free_ok_ff) begin
               ent_we             = 1'b1;
               ent_waddr          = free_idx_ff;
               ent_wdata.key      = cur_ff.key;
               ent_wdata.ts_start = cur_ff.now_us;
               ent_wdata.ts_stop  = cur_ff.now_us;
               ent_wdata.bytes    = BYTE_W'(cur_ff.len);
               ent_wdata.pkts     = PKT_W'(1);
               valid_in[free_idx_ff] = 1'b1;
               ring_we            = 1'b1;
               ring_wdata         = '{idx: free_idx_ff, chk: cur_ff.now_us};
               count_in           = count_ff + 1'b1;
               state_in           = ST_IDLE;
            end else if (out_free) begin
               out_vld_in          = 1'b1;
               out_in.kind         = KIND_DROP;
               out_in.rec.key      = cur_ff.key;
               out_in.rec.ts_start = cur_ff.now_us;
               out_in.rec.ts_stop  = cur_ff.now_us;
               out_in.rec.bytes    = BYTE_W'(cur_ff.len);
               out_in.rec.pkts     = PKT_W'(1);
               out_in.last         = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_TLIM: begin
            limit_in  = (cur_ff.now_us >= TS_W'(idle_us)) ?
                        cur_ff.now_us - TS_W'(idle_us) : '0;
            visits_in = count_ff;
            v_in      = '0;
            state_in  = ST_TRD;
         end
         ST_TRD: begin
            if (v_ff < visits_ff && count_ff != '0) begin
               head_in  = (head_ff == IW'(FLOW_ENTRIES - 1)) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               v_in     = v_ff + 1'b1;
               state_in = ST_TEN;
            end else begin
               state_in = ST_TEND;
            end
         end
         ST_TEN: begin
            e_in      = ring_rdata_ff.idx;
            chk_in    = ring_rdata_ff.chk;
            ent_raddr = ring_rdata_ff.idx;
            state_in  = ST_TDEC;
         end
         ST_TDEC: begin
            // keep the entry read steady while the output is stalled
            ent_raddr = e_ff;
            if (ent_rdata_ff.ts_stop < limit_ff) begin
               // hold one export back so the final one can carry last
               if (!pend_vld_ff || out_free) begin
                  if (pend_vld_ff) begin
                     out_vld_in = 1'b1;
                     out_in     = pend_ff;
                  end
                  pend_vld_in  = 1'b1;
                  pend_in.kind = KIND_IDLE;
                  pend_in.rec  = ent_rdata_ff;
                  pend_in.last = 1'b0;
                  valid_in[e_ff] = 1'b0;
                  state_in     = ST_TRD;
               end
            end else begin
               ring_we  = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = (chk_ff > limit_ff) ? ST_TEND : ST_TRD;
            end
         end
         ST_TEND: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_vld_in   = 1'b1;
               out_in       = pend_ff;
               out_in.last  = 1'b1;
               pend_vld_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rdata_ff <= ent_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_rdata_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         head_ff     <= '0;
         count_ff    <= '0;
         p_vld_ff    <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         p_vld_ff    <= p_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      iss_ff      <= iss_in;
      p_idx_ff    <= p_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rec_ff  <= hit_rec_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      age_gt_ff   <= age_gt_in;
      limit_ff    <= limit_in;
      visits_ff   <= visits_in;
      v_ff        <= v_in;
      e_ff        <= e_in;
      chk_ff      <= chk_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.kind         = out_ff.kind;
   assign rsp_ch.rec_src_ip   = out_ff.rec.key.sip;
   assign rsp_ch.rec_dst_ip   = out_ff.rec.key.dip;
   assign rsp_ch.rec_l4_sport = out_ff.rec.key.sport;
   assign rsp_ch.rec_l4_dport = out_ff.rec.key.dport;
   assign rsp_ch.rec_protocol = out_ff.rec.key.proto;
   assign rsp_ch.start_us     = out_ff.rec.ts_start;
   assign rsp_ch.end_us       = out_ff.rec.ts_stop;
   assign rsp_ch.byte_count   = out_ff.rec.bytes;
   assign rsp_ch.packet_count = out_ff.rec.pkts;
   assign rsp_ch.last         = out_ff.last;

endmodule

@@ rtl/core/flow_meter_idle_active_timeout_top.sv @@
// ----------------------------------------------------------------------------
// flow_meter_idle_active_timeout_top
// Five-tuple flow cache with idle and active timeout export.
// req_ch takes packet words (mode 0) and sweep tick words (mode 1); rsp_ch
// gives flow records, last set on the final record of a word; csr_ch writes
// the idle (index 0) and active (index 1) timeouts in ms, always ready.
// A packet word runs a key scan that reads one table entry per cycle from
// the read port of the flow memory, stopping at the first hit.
// A tick word visits up to FLOW_ENTRIES ring slots, reading each ring slot
// and then its table entry; the sweep can stop early. The engine finishes
// each word before it takes the next one from the queue.
// A two-word queue sits ahead of the engine and one output register behind
// it, so new words are taken while a record waits on a stalled receiver;
// the engine only halts when it needs the output register.
// Reset empties the table and ring at once and loads timeouts 500 / 100 ms.
// ----------------------------------------------------------------------------
module flow_meter_idle_active_timeout_top
   import fmit_pkg::*;
#(
   parameter int FLOW_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   fmit_req_if.sink    req_ch,
   fmit_rsp_if.source  rsp_ch,
   fmit_csr_if.sink    csr_ch
);

   logic [US_W-1:0] idle_us_ff, idle_us_in;
   logic [US_W-1:0] act_lim_ff, act_lim_in;
   logic [US_W-1:0] ms_scaled;
   logic            csr_we;
   logic            q_vld;
   logic            q_pop;
   item_type        q_item;

   assign csr_ch.ready = 1'b1;
   assign csr_we       = csr_ch.valid && csr_ch.ready;
   assign ms_scaled    = US_W'(csr_ch.data) * US_W'(US_PER_MS);

   // active limit kept as ms*1000+999 so whole-ms age compares as plain us
   always_comb begin
      idle_us_in = idle_us_ff;
      act_lim_in = act_lim_ff;
      if (csr_we) begin
         if (csr_ch.index == CSR_IDLE_TIMEOUT) begin
            idle_us_in = ms_scaled;
         end else if (csr_ch.index == CSR_ACTIVE_TIMEOUT) begin
            act_lim_in = ms_scaled + US_W'(MS_ROUND);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_us_ff <= US_W'(IDLE_MS_RST) * US_W'(US_PER_MS);
         act_lim_ff <= US_W'(ACTIVE_MS_RST) * US_W'(US_PER_MS) + US_W'(MS_ROUND);
      end else begin
         idle_us_ff <= idle_us_in;
         act_lim_ff <= act_lim_in;
      end
   end

   fmit_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_vld  (q_vld),
      .q_pop  (q_pop),
      .q_item (q_item)
   );

   fmit_engine #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_vld      (q_vld),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .idle_us    (idle_us_ff),
      .act_lim_us (act_lim_ff),
      .rsp_ch     (rsp_ch)
   );

endmodule

@@ rtl/core/fmit_checker.sv @@
// ----------------------------------------------------------------------------
// fmit_checker
// port level checks on the flow meter result channel
// ----------------------------------------------------------------------------
`include "flow_meter_idle_active_timeout_top_macros.svh"

module fmit_checker
   import fmit_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  kind,
   input logic [47:0] start_us,
   input logic [47:0] end_us,
   input logic [31:0] packet_count,
   input logic        last
);

   logic rsp_stall;
   logic drop_ok;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign drop_ok   = (start_us == end_us) && (packet_count == 32'd1);

   `FMIT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(kind) && $stable(start_us))

   // a packet word causes at most one record, so it is always the final one
   `FMIT_ASSERT_COMB(a_single_last, !rsp_valid || kind == KIND_IDLE || last)

   `FMIT_ASSERT_COMB(a_drop_shape, !rsp_valid || kind != KIND_DROP || drop_ok)

   `FMIT_ASSERT_COMB(a_interval_order, !rsp_valid || kind != KIND_ACTIVE || start_us <= end_us)

endmodule

bind flow_meter_idle_active_timeout_top fmit_checker u_fmit_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .kind         (rsp_ch.kind),
   .start_us     (rsp_ch.start_us),
   .end_us       (rsp_ch.end_us),
   .packet_count (rsp_ch.packet_count),
   .last         (rsp_ch.last)
);

@@ test/flow_meter_idle_active_timeout_top_tb.sv @@
// ----------------------------------------------------------------------------
// flow_meter_idle_active_timeout_top_tb
// Drives packet and tick words into the flow cache with bursty input and a
// stalling receiver, tracks the flow table and expiry ring alongside the
// design and checks every exported record field by field, in order.
// ----------------------------------------------------------------------------
module flow_meter_idle_active_timeout_top_tb;
   import fmit_pkg::*;

   localparam int ENTRIES     = 64;
   localparam int SETTLE_CYC  = 700;
   localparam int WATCHDOG    = 5000;
   localparam int HOLDOFF_CYC = 400;

   typedef enum logic [1:0] {OP_ITEM, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type       op;
      item_type          word;
      logic [IDX_W-1:0]  idx;
      logic [TO_W-1:0]   data;
   } stim_op_type;

   logic clock;
   logic reset;

   fmit_req_if req_ch ();
   fmit_rsp_if rsp_ch ();
   fmit_csr_if csr_ch ();

   flow_meter_idle_active_timeout_top #(.FLOW_ENTRIES(ENTRIES)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow flow table and expiry ring
   logic             tbl_valid [ENTRIES];
   flow_key_type     tbl_key   [ENTRIES];
   logic [TS_W-1:0]  tbl_start [ENTRIES];
   logic [TS_W-1:0]  tbl_end   [ENTRIES];
   logic [BYTE_W-1:0] tbl_bytes [ENTRIES];
   logic [PKT_W-1:0] tbl_pkts  [ENTRIES];
   int               ring_slot [ENTRIES];
   logic [TS_W-1:0]  ring_seen [ENTRIES];
   int               ring_rd;
   int               ring_len;
   logic [TO_W-1:0]  idle_ms;
   logic [TO_W-1:0]  active_ms;

   result_type  pending_records[$];
   stim_op_type stim_ops[$];

   int unsigned fail_count;
   int unsigned words_taken, records_seen, drops_seen, idle_seen, active_seen, csr_writes;
   int unsigned quiet_cycles;
   logic        req_took, csr_took;

   // driver state
   int  burst_left, gap_left, settle_cnt;
   // receiver state
   int  holdoff_left;
   logic holdoff_done;
   int unsigned rx_cycle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_record(logic [1:0] kind, flow_key_type k,
                                        logic [TS_W-1:0] st, logic [TS_W-1:0] en,
                                        logic [BYTE_W-1:0] by, logic [PKT_W-1:0] pk,
                                        logic last);
      result_type r;
      r.kind = kind;
      r.rec.key = k;
      r.rec.ts_start = st;
      r.rec.ts_stop = en;
      r.rec.bytes = by;
      r.rec.pkts = pk;
      r.last = last;
      pending_records.push_back(r);
   endfunction

   function automatic void count_packet(int e, logic [LEN_W-1:0] len);
      logic [BYTE_W:0] sum;
      sum = {1'b0, tbl_bytes[e]} + len;
      tbl_bytes[e] = sum[BYTE_W] ? '1 : sum[BYTE_W-1:0];
      if (tbl_pkts[e] != '1) tbl_pkts[e] = tbl_pkts[e] + 1;
   endfunction

   function automatic void ring_append(int e, logic [TS_W-1:0] t);
      int pos;
      if (ring_len >= ENTRIES) return;
      pos = (ring_rd + ring_len) % ENTRIES;
      ring_slot[pos] = e;
      ring_seen[pos] = t;
      ring_len++;
   endfunction

   function automatic void track_packet(item_type w);
      int hit, free_e;
      logic [TS_W-1:0] age;
      hit = -1;
      free_e = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_valid[i] && tbl_key[i] == w.key) begin
            if (hit < 0) hit = i;
         end else if (!tbl_valid[i] && free_e < 0) begin
            free_e = i;
         end
      end
      if (hit < 0) begin
         if (free_e < 0) begin
            queue_record(KIND_DROP, w.key, w.now_us, w.now_us, 48'(w.len), 32'd1, 1'b1);
            return;
         end
         tbl_valid[free_e] = 1'b1;
         tbl_key[free_e] = w.key;
         tbl_start[free_e] = w.now_us;
         tbl_end[free_e] = w.now_us;
         tbl_bytes[free_e] = '0;
         tbl_pkts[free_e] = '0;
         count_packet(free_e, w.len);
         ring_append(free_e, w.now_us);
         return;
      end
      age = (w.now_us >= tbl_start[hit]) ? w.now_us - tbl_start[hit] : '0;
      if (64'(age) / 64'd1000 > 64'(active_ms)) begin
         if (w.now_us > tbl_end[hit]) tbl_end[hit] = w.now_us;
         queue_record(KIND_ACTIVE, tbl_key[hit], tbl_start[hit], tbl_end[hit],
                      tbl_bytes[hit], tbl_pkts[hit], 1'b1);
         tbl_start[hit] = w.now_us;
         tbl_end[hit] = w.now_us;
         tbl_bytes[hit] = '0;
         tbl_pkts[hit] = '0;
      end
      if (w.now_us < tbl_start[hit]) tbl_start[hit] = w.now_us;
      if (w.now_us > tbl_end[hit]) tbl_end[hit] = w.now_us;
      count_packet(hit, w.len);
   endfunction

   function automatic void track_tick(logic [TS_W-1:0] now);
      logic [63:0] idle_us, lim;
      int visits, e, n;
      logic [TS_W-1:0] chk;
      idle_us = 64'(idle_ms) * 64'd1000;
      lim = (64'(now) >= idle_us) ? 64'(now) - idle_us : 64'd0;
      visits = ring_len;
      n = 0;
      for (int v = 0; v < visits && ring_len > 0; v++) begin
         e = ring_slot[ring_rd];
         chk = ring_seen[ring_rd];
         ring_rd = (ring_rd + 1) % ENTRIES;
         ring_len--;
         if (64'(tbl_end[e]) < lim) begin
            tbl_valid[e] = 1'b0;
            queue_record(KIND_IDLE, tbl_key[e], tbl_start[e], tbl_end[e],
                         tbl_bytes[e], tbl_pkts[e], 1'b0);
            n++;
         end else begin
            ring_append(e, now);
            if (64'(chk) > lim) break;
         end
      end
      if (n > 0) pending_records[pending_records.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // acceptance tracking, prediction, checking and watchdog
   always @(posedge clock) begin
      result_type want;
      item_type   w;
      if (reset) begin
         req_took <= 1'b0;
         csr_took <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_took <= req_ch.valid && req_ch.ready;
         csr_took <= csr_ch.valid && csr_ch.ready;
         if (csr_ch.valid && csr_ch.ready) begin
            csr_writes++;
            if (csr_ch.index == CSR_IDLE_TIMEOUT) idle_ms = csr_ch.data;
            else if (csr_ch.index == CSR_ACTIVE_TIMEOUT) active_ms = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready) begin
            words_taken++;
            w.mode = req_ch.mode;
            w.now_us = req_ch.now_us;
            w.key = '{req_ch.src_ip, req_ch.dst_ip, req_ch.l4_sport, req_ch.l4_dport,
                      req_ch.protocol};
            w.len = req_ch.packet_length;
            if (w.mode == MODE_TICK) track_tick(w.now_us);
            else track_packet(w);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            records_seen++;
            if (rsp_ch.kind == KIND_DROP) drops_seen++;
            else if (rsp_ch.kind == KIND_IDLE) idle_seen++;
            else active_seen++;
            if (pending_records.size() == 0) begin
               $error("record with no expectation waiting: kind %0d", rsp_ch.kind);
               fail_count++;
            end else begin
               want = pending_records.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_ch.kind));
               check_field("rec_src_ip", 64'(want.rec.key.sip), 64'(rsp_ch.rec_src_ip));
               check_field("rec_dst_ip", 64'(want.rec.key.dip), 64'(rsp_ch.rec_dst_ip));
               check_field("rec_l4_sport", 64'(want.rec.key.sport), 64'(rsp_ch.rec_l4_sport));
               check_field("rec_l4_dport", 64'(want.rec.key.dport), 64'(rsp_ch.rec_l4_dport));
               check_field("rec_protocol", 64'(want.rec.key.proto), 64'(rsp_ch.rec_protocol));
               check_field("start_us", 64'(want.rec.ts_start), 64'(rsp_ch.start_us));
               check_field("end_us", 64'(want.rec.ts_stop), 64'(rsp_ch.end_us));
               check_field("byte_count", 64'(want.rec.bytes), 64'(rsp_ch.byte_count));
               check_field("packet_count", 64'(want.rec.pkts), 64'(rsp_ch.packet_count));
               check_field("last", 64'(want.last), 64'(rsp_ch.last));
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG) begin
            $display("timeout: no transfer for %0d cycles, %0d records outstanding",
                     WATCHDOG, pending_records.size());
            $display("== FAIL ==");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // sender: bursts with gaps, idle waits before register writes
   always @(negedge clock) begin
      logic offer, csr_offer;
      stim_op_type op;
      if (reset) begin
         req_ch.valid <= 1'b0;
         csr_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_took && burst_left > 0) burst_left--;
         if (!(req_ch.valid && !req_took) && !(csr_ch.valid && !csr_took)) begin
            offer = 1'b0;
            csr_offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (stim_ops.size() > 0) begin
               op = stim_ops[0];
               case (op.op)
                  OP_DRAIN: begin
                     if (pending_records.size() != 0) begin
                        settle_cnt = 0;
                     end else if (settle_cnt >= SETTLE_CYC) begin
                        settle_cnt = 0;
                        void'(stim_ops.pop_front());
                     end else begin
                        settle_cnt++;
                     end
                  end
                  OP_CSR: begin
                     csr_offer = 1'b1;
                     csr_ch.index <= op.idx;
                     csr_ch.data <= op.data;
                     void'(stim_ops.pop_front());
                  end
                  default: begin
                     if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
                     end else begin
                        offer = 1'b1;
                        req_ch.mode <= op.word.mode;
                        req_ch.now_us <= op.word.now_us;
                        req_ch.src_ip <= op.word.key.sip;
                        req_ch.dst_ip <= op.word.key.dip;
                        req_ch.l4_sport <= op.word.key.sport;
                        req_ch.l4_dport <= op.word.key.dport;
                        req_ch.protocol <= op.word.key.proto;
                        req_ch.packet_length <= op.word.len;
                        void'(stim_ops.pop_front());
                     end
                  end
               endcase
            end
            req_ch.valid <= offer;
            csr_ch.valid <= csr_offer;
         end
      end
   end

   // receiver: random stalls, quiet stretches, one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!holdoff_done && records_seen >= 30) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYC;
            rsp_ch.ready <= 1'b0;
         end else if (rx_cycle[9]) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   function automatic flow_key_type rand_key();
      flow_key_type k;
      k.sip = $urandom;
      k.dip = $urandom;
      k.sport = $urandom_range(0, 65535);
      k.dport = $urandom_range(0, 65535);
      k.proto = $urandom_range(0, 255);
      return k;
   endfunction

   function automatic void add_word(logic mode, logic [TS_W-1:0] now, flow_key_type k,
                                    logic [LEN_W-1:0] len);
      stim_op_type op;
      op.op = OP_ITEM;
      op.word.mode = mode;
      op.word.now_us = now;
      op.word.key = k;
      op.word.len = len;
      op.idx = '0;
      op.data = '0;
      stim_ops.push_back(op);
   endfunction

   function automatic void add_drain();
      stim_op_type op;
      op.op = OP_DRAIN;
      op.word = '0;
      op.idx = '0;
      op.data = '0;
      stim_ops.push_back(op);
   endfunction

   function automatic void add_config(logic [TO_W-1:0] idle_v, logic [TO_W-1:0] active_v);
      stim_op_type op;
      add_drain();
      op.op = OP_CSR;
      op.word = '0;
      op.idx = CSR_IDLE_TIMEOUT;
      op.data = idle_v;
      stim_ops.push_back(op);
      op.idx = CSR_ACTIVE_TIMEOUT;
      op.data = active_v;
      stim_ops.push_back(op);
   endfunction

   initial begin
      flow_key_type ones_key, zero_key, pool[$];
      logic [TS_W-1:0] t, now;
      int pool_size, n_words, tick_pct;
      logic [TO_W-1:0] idle_set[5];
      logic [TO_W-1:0] active_set[5];
      int pool_set[5];
      int count_set[5];

      idle_set   = '{27'd1, 27'd0, 27'd86400000, 27'd3, 27'd5};
      active_set = '{27'd2, 27'd0, 27'd86400000, 27'd1, 27'd86400000};
      pool_set   = '{10, 6, 70, 20, 12};
      count_set  = '{40, 25, 90, 40, 30};

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_PACKET;
      req_ch.now_us = '0;
      req_ch.src_ip = '0;
      req_ch.dst_ip = '0;
      req_ch.l4_sport = '0;
      req_ch.l4_dport = '0;
      req_ch.protocol = '0;
      req_ch.packet_length = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_IDLE_TIMEOUT;
      csr_ch.data = '0;
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      ring_rd = 0;
      ring_len = 0;
      idle_ms = IDLE_MS_RST;
      active_ms = ACTIVE_MS_RST;
      burst_left = 0;
      gap_left = 0;
      settle_cnt = 0;
      holdoff_left = 0;
      holdoff_done = 1'b0;
      rx_cycle = 0;
      fail_count = 0;

      // directed words under the reset timeouts
      ones_key = '1;
      zero_key = '0;
      add_word(MODE_TICK, 48'd0, zero_key, 16'd0);             // empty ring
      add_word(MODE_PACKET, 48'd1000, ones_key, 16'hFFFF);
      add_word(MODE_PACKET, 48'd0, zero_key, 16'd0);
      add_word(MODE_PACKET, 48'd2000, ones_key, 16'd100);
      add_word(MODE_PACKET, 48'd500, ones_key, 16'd7);         // time runs backwards
      add_word(MODE_PACKET, 48'd200000, ones_key, 16'd1);      // active export
      add_word(MODE_PACKET, 48'd201000, zero_key, 16'd3);
      add_word(MODE_TICK, 48'd300000, ones_key, 16'hFFFF);     // now below idle timeout
      add_word(MODE_TICK, 48'd2000000, zero_key, 16'd0);       // both go idle
      add_word(MODE_PACKET, 48'hFFFF_FFFF_FFFF, rand_key(), 16'h5A5A);
      add_word(MODE_PACKET, 48'hFFFF_FFFF_FFFE, ones_key, 16'hA5A5);
      add_word(MODE_TICK, 48'hFFFF_FFFF_FFFF, ones_key, 16'd0);
      add_word(MODE_TICK, 48'hFFFF_FFFF_FFFF, zero_key, 16'd0);

      t = 48'd10_000_000;
      for (int ph = 0; ph < 5; ph++) begin
         add_config(idle_set[ph], active_set[ph]);
         // a leading tick clears out what the previous setting left behind
         t = t + 48'd5_000_000;
         add_word(MODE_TICK, t, rand_key(), 16'($urandom));
         pool_size = pool_set[ph];
         n_words = count_set[ph];
         tick_pct = (pool_size > ENTRIES) ? 10 : 20;
         pool.delete();
         for (int i = 0; i < pool_size; i++) pool.push_back(rand_key());
         for (int i = 0; i < n_words; i++) begin
            t = t + 48'($urandom_range(0, 3000));
            now = t;
            if ($urandom_range(0, 9) == 0) now = t - 48'($urandom_range(0, 5000));
            if ($urandom_range(0, 99) < tick_pct) begin
               add_word(MODE_TICK, now, rand_key(), 16'($urandom));
            end else if ($urandom_range(0, 19) == 0) begin
               add_word(MODE_PACKET, now, rand_key(), 16'($urandom));
            end else if (pool_size > ENTRIES && i < pool_size) begin
               add_word(MODE_PACKET, now, pool[i], 16'($urandom));
            end else begin
               add_word(MODE_PACKET, now, pool[$urandom_range(0, pool_size - 1)],
                        16'($urandom));
            end
         end
         // the sender waits for every record once per phase
         add_drain();
      end
      add_config(IDLE_MS_RST, ACTIVE_MS_RST);
      add_word(MODE_TICK, t + 48'd100_000_000, rand_key(), 16'd0);
      add_drain();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (stim_ops.size() == 0 && !req_ch.valid && !csr_ch.valid);
      wait (pending_records.size() == 0);
      repeat (SETTLE_CYC) @(posedge clock);

      if (pending_records.size() != 0) begin
         $error("%0d expected records never arrived", pending_records.size());
         fail_count++;
      end
      $display("covered %0d words and %0d register writes over six timeout settings",
               words_taken, csr_writes);
      $display("records: %0d idle, %0d active, %0d table-full drops",
               idle_seen, active_seen, drops_seen);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
